@@ design/hts_pkg.sv @@
// Package for the HTML tag stripper: scan phase codes, result entry type
// and the character constants. No dependencies.
`default_nettype none
package hts_pkg;

  // Scan phase, one-hot
  typedef enum logic [6:0] {
    PH_TEXT           = 7'b0000001,
    PH_OPEN           = 7'b0000010,
    PH_OPEN_B         = 7'b0000100,
    PH_OPEN_BANG      = 7'b0001000,
    PH_OPEN_BANG_DASH = 7'b0010000,
    PH_TAG            = 7'b0100000,
    PH_COMMENT        = 7'b1000000
  } phase_t;

  // One result of the stripper
  typedef struct packed {
    logic [7:0] data;   // plain-text byte
    logic       valid;  // 0 for a bare end marker
    logic       last;   // last result of the document
  } entry_t;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [7:0] ChLt    = 8'h3C;  // '<'
  localparam logic [7:0] ChGt    = 8'h3E;  // '>'
  localparam logic [7:0] ChBang  = 8'h21;  // '!'
  localparam logic [7:0] ChDash  = 8'h2D;  // '-'
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChBLc   = 8'h62;  // 'b'
  localparam logic [7:0] ChPLc   = 8'h70;  // 'p'
  localparam logic [7:0] ChRLc   = 8'h72;  // 'r'
  localparam logic [7:0] ChNul   = 8'h00;

endpackage
`default_nettype wire

@@ design/html_tag_stripper_top.sv @@
// HTML tag stripper top level: byte scanner plus a four-entry result queue.
// Depends on hts_pkg.
//
// Usage: raw HTML enters one byte per request on the in_ stream (in_tdata
// byte, in_tlast on the final byte of a document). Plain text leaves on the
// out_ stream: out_tdata is the byte, out_tuser is 1 for a real byte and 0
// for a bare end marker, out_tlast flags the last result of the document.
// Each input byte yields zero, one or two results; a final byte with no
// result yields one bare end marker.
// Throughput: one byte per cycle while in_tready is high. The scanner state
// updates in the accept cycle and results go into a four-entry queue drained
// one per cycle while out_tready is high; a <P tag can give two newlines, so
// in_tready drops while more than two results are queued.
// Reset (rst_n low, synchronous): scanner returns to text phase, the queue
// empties. A stalled receiver lets more than two results build up, after which
// in_tready goes low until room for two results returns.
`default_nettype none
module html_tag_stripper_top
  import hts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // in_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // out_valid
  output logic            out_tlast   // out_last
);

  // Scanner state
  phase_t     phase_r, phase_nxt;
  logic [1:0] dash_r, dash_nxt;
  logic       white_r, white_nxt;
  logic [1:0] nlrun_r, nlrun_nxt;
  logic       emitted_r, emitted_nxt;

  // Result queue
  entry_t         q_r [QDepth];
  logic [QAw-1:0] wr_r, rd_r;
  logic [QAw:0]   cnt_r;

  logic       in_acc, out_acc;
  logic [7:0] b, lc;
  entry_t     r0, r1;
  logic [1:0] nres;
  logic       is_ws;

  assign in_tready = (cnt_r <= (QAw+1)'(QDepth - 2));
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_acc   = out_tvalid && out_tready;

  assign b     = in_tdata;
  assign lc    = in_tdata | 8'h20;
  assign is_ws = (b == ChSpace) || (b == ChTab) || (b == ChCr) || (b == ChLf);

  // Next state and results of the current byte
  always_comb begin
    phase_nxt   = phase_r;
    dash_nxt    = dash_r;
    white_nxt   = white_r;
    nlrun_nxt   = nlrun_r;
    emitted_nxt = emitted_r;
    nres        = 2'd0;
    r0          = '{data: ChLf, valid: 1'b1, last: 1'b0};
    r1          = '{data: ChLf, valid: 1'b1, last: 1'b0};
    unique case (phase_r)
      PH_OPEN: begin
        if (b == ChGt) begin
          phase_nxt = PH_TEXT;
        end else if (b == ChBang) begin
          phase_nxt = PH_OPEN_BANG;
        end else if (lc == ChBLc) begin
          phase_nxt = PH_OPEN_B;
        end else if (lc == ChPLc) begin
          // top the newline run up to two
          nres      = (nlrun_r == 2'd0) ? 2'd2 : ((nlrun_r == 2'd1) ? 2'd1 : 2'd0);
          if (nlrun_r < 2'd2) emitted_nxt = 1'b1;
          nlrun_nxt = 2'd2;
          white_nxt = 1'b1;
          phase_nxt = PH_TAG;
        end else begin
          phase_nxt = PH_TAG;
        end
      end
      PH_OPEN_B: begin
        if (b == ChGt) begin
          phase_nxt = PH_TEXT;
        end else begin
          if (lc == ChRLc) begin
            nres        = 2'd1;
            emitted_nxt = 1'b1;
            white_nxt   = 1'b1;
            if (nlrun_r < 2'd2) nlrun_nxt = nlrun_r + 2'd1;
          end
          phase_nxt = PH_TAG;
        end
      end
      PH_OPEN_BANG: begin
        if (b == ChGt)        phase_nxt = PH_TEXT;
        else if (b == ChDash) phase_nxt = PH_OPEN_BANG_DASH;
        else                  phase_nxt = PH_TAG;
      end
      PH_OPEN_BANG_DASH: begin
        if (b == ChGt) begin
          phase_nxt = PH_TEXT;
        end else if (b == ChDash) begin
          phase_nxt = PH_COMMENT;
          dash_nxt  = 2'd0;
        end else begin
          phase_nxt = PH_TAG;
        end
      end
      PH_TAG: begin
        if (b == ChGt) phase_nxt = PH_TEXT;
      end
      PH_COMMENT: begin
        if (b == ChDash) begin
          if (dash_r < 2'd2) dash_nxt = dash_r + 2'd1;
        end else if ((b == ChGt) && (dash_r >= 2'd2)) begin
          phase_nxt = PH_TEXT;
          dash_nxt  = 2'd0;
        end else begin
          dash_nxt = 2'd0;
        end
      end
      default: begin
        // text phase, and any unused code
        phase_nxt = PH_TEXT;
        if (b == ChLt) begin
          phase_nxt = PH_OPEN;
        end else if (is_ws) begin
          if (!white_r && emitted_r) begin
            nres        = 2'd1;
            r0.data     = ChSpace;
            emitted_nxt = 1'b1;
          end
          white_nxt = 1'b1;
        end else begin
          nres        = 2'd1;
          r0.data     = b;
          emitted_nxt = 1'b1;
          white_nxt   = 1'b0;
          nlrun_nxt   = 2'd0;
        end
      end
    endcase

    // end of document: mark the last result, fall back to reset state
    if (in_tlast) begin
      if (nres == 2'd0) begin
        nres = 2'd1;
        r0   = '{data: ChNul, valid: 1'b0, last: 1'b0};
      end
      if (nres == 2'd2) r1.last = 1'b1;
      else              r0.last = 1'b1;
      phase_nxt   = PH_TEXT;
      dash_nxt    = 2'd0;
      white_nxt   = 1'b0;
      nlrun_nxt   = 2'd0;
      emitted_nxt = 1'b0;
    end
  end

  // Scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TEXT;
      dash_r    <= 2'd0;
      white_r   <= 1'b0;
      nlrun_r   <= 2'd0;
      emitted_r <= 1'b0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      dash_r    <= dash_nxt;
      white_r   <= white_nxt;
      nlrun_r   <= nlrun_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  // Queue pointers and fill count
  logic [1:0] push_n;
  assign push_n = in_acc ? nres : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + QAw'(push_n);
      if (out_acc) rd_r <= rd_r + QAw'(1);
      cnt_r <= cnt_r + (QAw+1)'(push_n) - (QAw+1)'(out_acc);
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_r] <= r0;
    if (push_n == 2'd2) q_r[wr_r + QAw'(1)] <= r1;
  end

  assign out_tdata = q_r[rd_r].data;
  assign out_tuser = q_r[rd_r].valid;
  assign out_tlast = q_r[rd_r].last;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAw+1)'(QDepth))
    else $error("result queue overflow");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_acc) |=> (cnt_r == $past(cnt_r) + (QAw+1)'($past(push_n))))
    else $error("fill count does not follow pushes");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_r - rd_r) == cnt_r[QAw-1:0])
    else $error("queue pointers disagree with fill count");

  a_last_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (phase_r == PH_TEXT && !emitted_r && nlrun_r == 2'd0))
    else $error("scanner state not cleared after last byte");

endmodule
`default_nettype wire
